// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the delta nibble encoder checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is held
`define ADNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define ADNE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/adne_pkg.sv
// ----------------------------------------------------------------------------
// adne_pkg
// types, step table and quantizer shared by the delta nibble encoder
// ----------------------------------------------------------------------------
package adne_pkg;

  typedef logic [3:0] code_t;
  typedef logic [7:0] sample_t;

  localparam sample_t PRED_RESET = 8'd128;

  // predictor step for each code, two's complement, added mod 256
  localparam sample_t STEP_TABLE [16] = '{
    8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE, 8'hFF,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h7F
  };

  // map a signed difference (-255..255) onto a 4-bit code
  function automatic code_t quantize(input logic signed [8:0] d);
    code_t c;
    if (d <= -9'sd96)      c = 4'd0;
    else if (d <= -9'sd48) c = 4'd1;
    else if (d <= -9'sd24) c = 4'd2;
    else if (d <= -9'sd12) c = 4'd3;
    else if (d <= -9'sd6)  c = 4'd4;
    else if (d <= -9'sd3)  c = 4'd5;
    else if (d == -9'sd2)  c = 4'd6;
    else if (d <= 9'sd0)   c = 4'd7;
    else if (d == 9'sd1)   c = 4'd8;
    else if (d <= 9'sd3)   c = 4'd9;
    else if (d <= 9'sd6)   c = 4'd10;
    else if (d <= 9'sd12)  c = 4'd11;
    else if (d <= 9'sd24)  c = 4'd12;
    else if (d <= 9'sd48)  c = 4'd13;
    else if (d <= 9'sd95)  c = 4'd14;
    else                   c = 4'd15;
    return c;
  endfunction

endpackage

// File: design/adne_quant.sv
// ----------------------------------------------------------------------------
// adne_quant
// codes one sample against the predictor and returns the moved predictor
// ----------------------------------------------------------------------------
module adne_quant
  import adne_pkg::*;
(
  input  sample_t sample,
  input  sample_t pred_in,
  output code_t   code,
  output sample_t pred_out
);

  logic signed [8:0] diff;

  // difference between sample and predictor, nine bits signed
  assign diff = $signed({1'b0, sample}) - $signed({1'b0, pred_in});

  // quantize, then step the predictor with wraparound
  assign code     = quantize(diff);
  assign pred_out = pred_in + STEP_TABLE[code];

endmodule

// File: design/audio_delta_nibble_encoder.sv
// ----------------------------------------------------------------------------
// audio_delta_nibble_encoder
// 4-bit delta coder for pairs of unsigned 8-bit audio samples
// ----------------------------------------------------------------------------
// Input beat: in_sample_first, in_sample_second and in_restart, taken on a
// clock edge where in_valid is high and in_stall is low. Output beat:
// out_packed_codes (first code in bits 3:0, second in bits 7:4), taken where
// out_valid is high and out_stall is low. Exactly one output beat per input.
// A beat is captured in an input register; once the output register can take
// a byte, both samples are coded in series against the predictor and the byte
// lands in the output register, which raises out_valid.
// Throughput is one pair per cycle while out_stall is low, set by the single
// compute stage between the two registers, which also updates the predictor.
// in_restart loads 128 into the predictor ahead of the first sample.
// Reset empties both registers and sets the predictor to 128.
// While out_stall holds a waiting result, the input register still takes a
// beat; in_stall rises only when both registers are full and out is stalled.
// ----------------------------------------------------------------------------
module audio_delta_nibble_encoder
  import adne_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  sample_t in_sample_first,
  input  sample_t in_sample_second,
  input  logic    in_restart,
  output logic    out_valid,
  input  logic    out_stall,
  output sample_t out_packed_codes
);

  logic    s1_vld_r;
  sample_t s1_first_r;
  sample_t s1_second_r;
  logic    s1_restart_r;
  logic    out_vld_r;
  sample_t out_codes_r;
  sample_t pred_r;

  logic    advance;
  logic    fire;
  logic    s1_vld_nxt;
  logic    out_vld_nxt;
  sample_t pred_start;
  sample_t pred_mid;
  sample_t pred_nxt;
  code_t   code_lo;
  code_t   code_hi;

  // handshake: output stage moves when empty or drained
  assign advance  = !out_vld_r || !out_stall;
  assign fire     = s1_vld_r && advance;
  assign in_stall = s1_vld_r && !advance;

  assign s1_vld_nxt  = (in_valid && !in_stall) || (s1_vld_r && !advance);
  assign out_vld_nxt = advance ? s1_vld_r : out_vld_r;

  // predictor seen by the first sample
  assign pred_start = s1_restart_r ? PRED_RESET : pred_r;

  // two quantize-and-step passes in series
  adne_quant u_quant_lo (
    .sample   (s1_first_r),
    .pred_in  (pred_start),
    .code     (code_lo),
    .pred_out (pred_mid)
  );

  adne_quant u_quant_hi (
    .sample   (s1_second_r),
    .pred_in  (pred_mid),
    .code     (code_hi),
    .pred_out (pred_nxt)
  );

  // control state and predictor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pred_r    <= PRED_RESET;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (fire) begin
        pred_r <= pred_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_first_r   <= in_sample_first;
      s1_second_r  <= in_sample_second;
      s1_restart_r <= in_restart;
    end
    if (fire) begin
      out_codes_r <= {code_hi, code_lo};
    end
  end

  assign out_valid        = out_vld_r;
  assign out_packed_codes = out_codes_r;

endmodule

// File: design/adne_checker.sv
// ----------------------------------------------------------------------------
// adne_checker
// port-level checks on the delta nibble encoder, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adne_checker
  import adne_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_stall,
  input sample_t in_sample_first,
  input sample_t in_sample_second,
  input logic    in_restart,
  input logic    out_valid,
  input logic    out_stall,
  input sample_t out_packed_codes
);

  // a stalled result beat stays put
  `ADNE_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_packed_codes)), "stalled output beat changed")

  // a stalled input beat stays put
  `ADNE_ASSERT(a_in_hold, (in_valid && in_stall) |=> (in_valid && $stable({in_sample_first, in_sample_second, in_restart})), "stalled input beat changed")

  // back-pressure on the input only while a full output is stalled
  `ADNE_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without output stall")

  // reset leaves both channels empty and ready
  `ADNE_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_valid && !in_stall), "channels not empty after reset")

endmodule

bind audio_delta_nibble_encoder adne_checker u_adne_checker (.*);
